[hdl/bufr_pkg.sv]
`default_nettype none

package bufr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_CONT,
    PH_STOPPED
  } phase_t;

  typedef enum logic [2:0] {
    ST_RECEIVING = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_PARTNER   = 3'd2,
    ST_HEADER    = 3'd3,
    ST_SEQ       = 3'd4,
    ST_SHORT     = 3'd5,
    ST_OVERRUN   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_KEEPALIVE,
    ACT_STOP,
    ACT_FIRST_SOP,
    ACT_LEN_HI,
    ACT_LEN_LO,
    ACT_PAYLOAD,
    ACT_SEQ
  } action_t;

  localparam logic [1:0] CFG_EXP_CMD   = 2'd0;
  localparam logic [1:0] CFG_KEEPALIVE = 2'd1;
  localparam logic [1:0] CFG_ERROR     = 2'd2;

  localparam logic [7:0] EXP_CMD_RST   = 8'd131;
  localparam logic [7:0] KEEPALIVE_RST = 8'd130;
  localparam logic [7:0] ERROR_RST     = 8'd191;

  localparam logic [6:0] SEQ_MAX = 7'h7F;

  localparam logic [1:0] HDR_CMD   = 2'd1;
  localparam logic [1:0] HDR_LEN_H = 2'd2;
  localparam logic [1:0] HDR_DONE  = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] packet_byte;
    logic       start_of_packet;
    logic       end_of_packet;
  } item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       is_last;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

[hdl/bufr_in_reg.sv]
`default_nettype none

module bufr_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire bufr_pkg::item_t in_item,
  input  wire logic            adv,
  output logic                 go,
  output bufr_pkg::item_t      item
);

  logic            valid_r;
  logic            valid_nxt;
  logic            accept;
  bufr_pkg::item_t item_r;

  assign in_stall  = valid_r && !adv;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept || (valid_r && !adv);
  assign go        = valid_r && adv;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[hdl/bufr_core.sv]
`default_nettype none

module bufr_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_valid,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            go,
  input  wire bufr_pkg::item_t item,
  output logic                 res_valid,
  output bufr_pkg::result_t    res
);

  logic [7:0] exp_cmd_r;
  logic [7:0] keepalive_r;
  logic [7:0] error_r;

  bufr_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       hdr_pos_r, hdr_pos_nxt;
  logic [15:0]      msg_len_r, msg_len_nxt;
  logic [15:0]      pay_cnt_r, pay_cnt_nxt;
  logic [6:0]       last_seq_r, last_seq_nxt;
  logic             skip_r, skip_nxt;
  logic             seq_started_r, seq_started_nxt;

  bufr_pkg::action_t act;
  bufr_pkg::status_t stop_st;
  logic [7:0]        b;
  logic              sop;
  logic              eop;
  logic [15:0]       cnt_inc;
  logic              overrun;
  logic              complete;
  logic              seq_ok;

  assign b        = item.packet_byte;
  assign sop      = item.start_of_packet;
  assign eop      = item.end_of_packet;
  assign cnt_inc  = pay_cnt_r + 16'd1;
  assign overrun  = pay_cnt_r >= msg_len_r;
  assign complete = eop && (cnt_inc == msg_len_r);
  assign seq_ok   = seq_started_r ?
                    ((b == ({1'b0, last_seq_r} + 8'd1)) && (b <= {1'b0, bufr_pkg::SEQ_MAX})) :
                    ((b == 8'd0) || (b == 8'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r   <= bufr_pkg::EXP_CMD_RST;
      keepalive_r <= bufr_pkg::KEEPALIVE_RST;
      error_r     <= bufr_pkg::ERROR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bufr_pkg::CFG_EXP_CMD:   exp_cmd_r   <= cfg_data;
        bufr_pkg::CFG_KEEPALIVE: keepalive_r <= cfg_data;
        bufr_pkg::CFG_ERROR:     error_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the byte
  always_comb begin
    act     = bufr_pkg::ACT_NONE;
    stop_st = bufr_pkg::ST_RECEIVING;
    if (item.command) begin
      act = bufr_pkg::ACT_CLEAR;
    end else if (phase_r == bufr_pkg::PH_STOPPED) begin
      act = bufr_pkg::ACT_NONE;
    end else if (sop && (b == keepalive_r)) begin
      act = bufr_pkg::ACT_KEEPALIVE;
    end else if (sop && (b == error_r)) begin
      act     = bufr_pkg::ACT_STOP;
      stop_st = bufr_pkg::ST_PARTNER;
    end else if (!sop && (skip_r || (phase_r == bufr_pkg::PH_IDLE))) begin
      act = bufr_pkg::ACT_NONE;
    end else if (phase_r != bufr_pkg::PH_CONT) begin
      if (sop) begin
        if (b != exp_cmd_r) begin
          act     = bufr_pkg::ACT_STOP;
          stop_st = bufr_pkg::ST_HEADER;
        end else if (eop) begin
          act     = bufr_pkg::ACT_STOP;
          stop_st = bufr_pkg::ST_SHORT;
        end else begin
          act = bufr_pkg::ACT_FIRST_SOP;
        end
      end else if (hdr_pos_r == bufr_pkg::HDR_CMD || hdr_pos_r == bufr_pkg::HDR_LEN_H) begin
        if (eop) begin
          act     = bufr_pkg::ACT_STOP;
          stop_st = bufr_pkg::ST_SHORT;
        end else if (hdr_pos_r == bufr_pkg::HDR_CMD) begin
          act = bufr_pkg::ACT_LEN_HI;
        end else begin
          act = bufr_pkg::ACT_LEN_LO;
        end
      end else if (overrun) begin
        act     = bufr_pkg::ACT_STOP;
        stop_st = bufr_pkg::ST_OVERRUN;
      end else begin
        act = bufr_pkg::ACT_PAYLOAD;
      end
    end else begin
      if (sop) begin
        if (!seq_ok) begin
          act     = bufr_pkg::ACT_STOP;
          stop_st = bufr_pkg::ST_SEQ;
        end else begin
          act = bufr_pkg::ACT_SEQ;
        end
      end else if (overrun) begin
        act     = bufr_pkg::ACT_STOP;
        stop_st = bufr_pkg::ST_OVERRUN;
      end else begin
        act = bufr_pkg::ACT_PAYLOAD;
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    hdr_pos_nxt     = hdr_pos_r;
    msg_len_nxt     = msg_len_r;
    pay_cnt_nxt     = pay_cnt_r;
    last_seq_nxt    = last_seq_r;
    skip_nxt        = skip_r;
    seq_started_nxt = seq_started_r;
    case (act)
      bufr_pkg::ACT_CLEAR: begin
        phase_nxt       = bufr_pkg::PH_IDLE;
        hdr_pos_nxt     = 2'd0;
        msg_len_nxt     = 16'd0;
        pay_cnt_nxt     = 16'd0;
        last_seq_nxt    = 7'd0;
        skip_nxt        = 1'b0;
        seq_started_nxt = 1'b0;
      end
      bufr_pkg::ACT_KEEPALIVE: begin
        skip_nxt = 1'b1;
      end
      bufr_pkg::ACT_STOP: begin
        phase_nxt = bufr_pkg::PH_STOPPED;
      end
      bufr_pkg::ACT_FIRST_SOP: begin
        phase_nxt   = bufr_pkg::PH_FIRST;
        hdr_pos_nxt = bufr_pkg::HDR_CMD;
        msg_len_nxt = 16'd0;
        pay_cnt_nxt = 16'd0;
        skip_nxt    = eop;
      end
      bufr_pkg::ACT_LEN_HI: begin
        msg_len_nxt = {b, 8'd0};
        hdr_pos_nxt = bufr_pkg::HDR_LEN_H;
        skip_nxt    = eop;
      end
      bufr_pkg::ACT_LEN_LO: begin
        msg_len_nxt = {msg_len_r[15:8], b};
        hdr_pos_nxt = bufr_pkg::HDR_DONE;
        skip_nxt    = eop;
      end
      bufr_pkg::ACT_PAYLOAD: begin
        pay_cnt_nxt = cnt_inc;
        skip_nxt    = eop;
        if (complete) begin
          phase_nxt = bufr_pkg::PH_STOPPED;
        end else if (eop) begin
          phase_nxt = bufr_pkg::PH_CONT;
        end
      end
      bufr_pkg::ACT_SEQ: begin
        last_seq_nxt    = b[6:0];
        seq_started_nxt = 1'b1;
        skip_nxt        = eop;
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    res_valid         = 1'b0;
    res.payload_byte  = 8'd0;
    res.payload_valid = 1'b0;
    res.is_last       = 1'b0;
    res.status        = bufr_pkg::ST_RECEIVING;
    case (act)
      bufr_pkg::ACT_STOP: begin
        res_valid  = 1'b1;
        res.status = stop_st;
      end
      bufr_pkg::ACT_PAYLOAD: begin
        res_valid         = 1'b1;
        res.payload_byte  = b;
        res.payload_valid = 1'b1;
        res.is_last       = complete;
        res.status        = complete ? bufr_pkg::ST_COMPLETE : bufr_pkg::ST_RECEIVING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= bufr_pkg::PH_IDLE;
      hdr_pos_r     <= 2'd0;
      msg_len_r     <= 16'd0;
      pay_cnt_r     <= 16'd0;
      last_seq_r    <= 7'd0;
      skip_r        <= 1'b0;
      seq_started_r <= 1'b0;
    end else if (go) begin
      phase_r       <= phase_nxt;
      hdr_pos_r     <= hdr_pos_nxt;
      msg_len_r     <= msg_len_nxt;
      pay_cnt_r     <= pay_cnt_nxt;
      last_seq_r    <= last_seq_nxt;
      skip_r        <= skip_nxt;
      seq_started_r <= seq_started_nxt;
    end
  end

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bufr_pkg::PH_STOPPED && !(go && item.command))
      |=> phase_r == bufr_pkg::PH_STOPPED)
    else $error("stopped message left without a clear");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pay_cnt_r <= msg_len_r)
    else $error("payload count above message length");

  a_last_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_valid && res.is_last)
      |-> (res.payload_valid && res.status == bufr_pkg::ST_COMPLETE))
    else $error("last byte without complete status");

endmodule

`default_nettype wire

[hdl/bufr_out_reg.sv]
`default_nettype none

module bufr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic              res_valid,
  input  wire bufr_pkg::result_t res,
  output logic                   adv,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bufr_pkg::result_t      out_res
);

  logic              valid_r;
  logic              valid_nxt;
  logic              load;
  bufr_pkg::result_t res_r;

  assign adv       = !valid_r || !out_stall;
  assign load      = go && res_valid;
  assign valid_nxt = load || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

[hdl/ble_u2f_frame_reassembler.sv]
// reassembles u2f response messages from ble notification packet bytes
// input channel: one packet byte per request (in_valid / in_stall), with
//   start and end of packet flags; in_command = 1 clears and arms for a
//   new message and gives no result
// output channel: one result per payload byte, and one per item that ends
//   the message with an error (out_valid / out_stall); out_status gives
//   receiving, complete, partner error, header mismatch, sequence error,
//   too short or overrun
// config channel: cfg_valid / cfg_ready, cfg_index 0 expected command,
//   1 keep-alive code, 2 partner error code; cfg_ready is always high
// throughput: one request per cycle unless out_stall holds a pending result;
//   the input register and the result register are the only stages, and all
//   per-byte checks and counter updates sit between them
// reset: synchronous active-low rst_n empties both stages, clears the
//   message state and loads the register defaults 131, 130 and 191
// stall: while out_stall holds a pending result, the next request waits in
//   the input register and in_stall rises only once that register is full
`default_nettype none

module ble_u2f_frame_reassembler (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_command,
  input  wire logic [7:0] in_packet_byte,
  input  wire logic       in_start_of_packet,
  input  wire logic       in_end_of_packet,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_payload_byte,
  output logic            out_payload_valid,
  output logic            out_is_last,
  output logic [2:0]      out_status,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  bufr_pkg::item_t   in_item;
  bufr_pkg::item_t   item;
  bufr_pkg::result_t res;
  bufr_pkg::result_t out_res;
  logic              adv;
  logic              go;
  logic              res_valid;

  assign cfg_ready = 1'b1;

  assign in_item.command         = in_command;
  assign in_item.packet_byte     = in_packet_byte;
  assign in_item.start_of_packet = in_start_of_packet;
  assign in_item.end_of_packet   = in_end_of_packet;

  bufr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .go       (go),
    .item     (item)
  );

  bufr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  bufr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_valid = out_res.payload_valid;
  assign out_is_last       = out_res.is_last;
  assign out_status        = out_res.status;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with a free result register");

endmodule

`default_nettype wire

[tb/frame_payload_checker.sv]
`timescale 1ns / 100ps

module frame_payload_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_packet_byte,
  input  logic       in_start_of_packet,
  input  logic       in_end_of_packet,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_payload_byte,
  input  logic       out_payload_valid,
  input  logic       out_is_last,
  input  logic [2:0] out_status,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatch_count,
  output int         results_pending
);

  logic [7:0]          exp_cmd;
  logic [7:0]          ka_code;
  logic [7:0]          err_code;
  bufr_pkg::phase_t    phase;
  logic [1:0]          hdr_pos;
  logic [15:0]         msg_len;
  logic [15:0]         pay_cnt;
  logic [6:0]          last_seq;
  logic                skip_pkt;
  logic                seen_first;
  logic                seq_started;
  bufr_pkg::result_t   payload_q[$];
  bufr_pkg::result_t   want;
  bufr_pkg::result_t   got;
  int                  mismatches = 0;
  int                  depth = 0;

  assign mismatch_count  = mismatches;
  assign results_pending = depth;

  task automatic clear_msg();
    phase       = bufr_pkg::PH_IDLE;
    hdr_pos     = '0;
    msg_len     = '0;
    pay_cnt     = '0;
    last_seq    = '0;
    skip_pkt    = 1'b0;
    seen_first  = 1'b0;
    seq_started = 1'b0;
  endtask

  task automatic push_result(input logic [7:0] b, input logic pv, input logic last,
                             input bufr_pkg::status_t st);
    bufr_pkg::result_t r;
    r = '{b, pv, last, st};
    payload_q.insert(payload_q.size(), r);
  endtask

  task automatic stop_msg(input bufr_pkg::status_t st);
    phase = bufr_pkg::PH_STOPPED;
    push_result(8'h00, 1'b0, 1'b0, st);
  endtask

  task automatic take_payload(input logic [7:0] b, input logic eop);
    if (pay_cnt >= msg_len) begin
      stop_msg(bufr_pkg::ST_OVERRUN);
    end else begin
      pay_cnt = pay_cnt + 16'd1;
      if (eop && pay_cnt == msg_len) begin
        phase = bufr_pkg::PH_STOPPED;
        push_result(b, 1'b1, 1'b1, bufr_pkg::ST_COMPLETE);
      end else begin
        push_result(b, 1'b1, 1'b0, bufr_pkg::ST_RECEIVING);
      end
    end
  endtask

  task automatic reassemble_byte(input logic cmd, input logic [7:0] b, input logic sop,
                                 input logic eop);
    int bi;
    bit ok;
    bi = int'(b);
    if (cmd) begin
      clear_msg();
      return;
    end
    if (phase == bufr_pkg::PH_STOPPED) return;
    if (sop) begin
      skip_pkt = 1'b0;
      if (b == ka_code) begin
        skip_pkt = 1'b1;
        return;
      end
      if (b == err_code) begin
        stop_msg(bufr_pkg::ST_PARTNER);
        return;
      end
    end else if (skip_pkt || phase == bufr_pkg::PH_IDLE) begin
      return;
    end
    if (eop) skip_pkt = 1'b1;
    // first packet: command byte, two length bytes, then payload
    if (phase != bufr_pkg::PH_CONT) begin
      if (sop) begin
        if (b != exp_cmd) begin
          stop_msg(bufr_pkg::ST_HEADER);
          return;
        end
        phase   = bufr_pkg::PH_FIRST;
        hdr_pos = bufr_pkg::HDR_CMD;
        msg_len = '0;
        pay_cnt = '0;
        if (eop) stop_msg(bufr_pkg::ST_SHORT);
        return;
      end
      if (hdr_pos == bufr_pkg::HDR_CMD) begin
        msg_len = {b, 8'h00};
        hdr_pos = bufr_pkg::HDR_LEN_H;
      end else if (hdr_pos == bufr_pkg::HDR_LEN_H) begin
        msg_len[7:0] = b;
        hdr_pos      = bufr_pkg::HDR_DONE;
      end else begin
        take_payload(b, eop);
        if (phase == bufr_pkg::PH_STOPPED) return;
      end
      if (eop) begin
        if (pay_cnt == '0) begin
          stop_msg(bufr_pkg::ST_SHORT);
        end else begin
          seen_first = 1'b1;
          phase      = bufr_pkg::PH_CONT;
        end
      end
      return;
    end
    // continuation packets start with a sequence byte
    if (sop) begin
      if (seq_started) begin
        ok = (bi == int'(last_seq) + 1) && bi >= 1 &&
             bi <= int'(bufr_pkg::SEQ_MAX);
      end else begin
        ok = (bi <= 1);
      end
      if (!ok) begin
        stop_msg(bufr_pkg::ST_SEQ);
      end else begin
        last_seq    = b[6:0];
        seq_started = 1'b1;
      end
      return;
    end
    take_payload(b, eop);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd  = bufr_pkg::EXP_CMD_RST;
      ka_code  = bufr_pkg::KEEPALIVE_RST;
      err_code = bufr_pkg::ERROR_RST;
      clear_msg();
      payload_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bufr_pkg::CFG_EXP_CMD:   exp_cmd  = cfg_data;
          bufr_pkg::CFG_KEEPALIVE: ka_code  = cfg_data;
          bufr_pkg::CFG_ERROR:     err_code = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_payload_byte, out_payload_valid, out_is_last,
                bufr_pkg::status_t'(out_status)};
        if (payload_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, %s", $time,
                   $sformatf("got byte %h valid %b last %b status %0d", got.payload_byte,
                             got.payload_valid, got.is_last, got.status));
        end else begin
          want = payload_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: result mismatch, expected byte %h valid %b last %b status %0d, %s",
                     $time, want.payload_byte, want.payload_valid, want.is_last, want.status,
                     $sformatf("got byte %h valid %b last %b status %0d", got.payload_byte,
                               got.payload_valid, got.is_last, got.status));
          end
        end
      end
      if (in_valid && !in_stall) begin
        reassemble_byte(in_command, in_packet_byte, in_start_of_packet, in_end_of_packet);
      end
    end
    depth = payload_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int MAX_GAP       = 13;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int TIMEOUT_NS    = 5000000;

  typedef enum int {
    FLT_NONE,
    FLT_HEADER,
    FLT_SEQ,
    FLT_OVERRUN,
    FLT_PARTNER,
    FLT_TRUNC
  } fault_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_command = 1'b0;
  logic [7:0] in_packet_byte = 8'h00;
  logic       in_start_of_packet = 1'b0;
  logic       in_end_of_packet = 1'b0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = bufr_pkg::CFG_EXP_CMD;
  logic [7:0] cfg_data = 8'h00;
  wire        in_stall;
  wire        out_valid;
  wire  [7:0] out_payload_byte;
  wire        out_payload_valid;
  wire        out_is_last;
  wire  [2:0] out_status;
  wire        cfg_ready;
  int         fail_count;
  int         results_pending;

  logic [7:0] cur_cmd = bufr_pkg::EXP_CMD_RST;
  logic [7:0] cur_ka = bufr_pkg::KEEPALIVE_RST;
  logic [7:0] cur_err = bufr_pkg::ERROR_RST;
  logic [7:0] pkt_q[$];
  bit         quiet = 1'b0;
  int         counted_items = 0;
  int         hold_requests = 0;
  int         hold_served = 0;

  ble_u2f_frame_reassembler u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_packet_byte     (in_packet_byte),
    .in_start_of_packet (in_start_of_packet),
    .in_end_of_packet   (in_end_of_packet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_payload_valid  (out_payload_valid),
    .out_is_last        (out_is_last),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  frame_payload_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_packet_byte     (in_packet_byte),
    .in_start_of_packet (in_start_of_packet),
    .in_end_of_packet   (in_end_of_packet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_payload_valid  (out_payload_valid),
    .out_is_last        (out_is_last),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (fail_count),
    .results_pending    (results_pending)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  // result side: random stall before each result, one long hold on request
  initial begin : result_sink
    int n;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_served != hold_requests) begin
        n = LONG_HOLD;
        hold_served++;
      end else begin
        n = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] b, input logic sop,
                           input logic eop);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_packet_byte     <= b;
    in_start_of_packet <= sop;
    in_end_of_packet   <= eop;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_packet(input bit counted);
    for (int i = 0; i < pkt_q.size(); i++)
      send_item(1'b0, pkt_q[i], i == 0, i == pkt_q.size() - 1);
    if (counted) counted_items += pkt_q.size();
    pkt_q.delete();
  endtask

  task automatic add_byte(input logic [7:0] val);
    pkt_q.insert(pkt_q.size(), val);
  endtask

  task automatic add_payload(input int n, input bit extra);
    repeat (n + int'(extra)) add_byte(8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(input logic [7:0] cmd, input logic [7:0] ka,
                              input logic [7:0] err);
    write_reg(bufr_pkg::CFG_EXP_CMD, cmd);
    write_reg(bufr_pkg::CFG_KEEPALIVE, ka);
    write_reg(bufr_pkg::CFG_ERROR, err);
    cfg_valid <= 1'b0;
    cur_cmd = cmd;
    cur_ka  = ka;
    cur_err = err;
  endtask

  // one message request: optional clear, first packet, continuations, optional fault
  task automatic send_message(input int len, input bit full, input bit chain);
    fault_t fault;
    int     pick;
    int     n;
    int     remain;
    int     seq;
    int     cut;
    pick  = $urandom_range(0, 11);
    fault = (full || chain || pick > int'(FLT_TRUNC)) ? FLT_NONE : fault_t'(pick);
    if ($urandom_range(0, 9) != 0) begin
      send_item(1'b1, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 7) == 0) send_item(1'b0, 8'($urandom), 1'b0, 1'($urandom));
    add_byte(fault == FLT_HEADER ? cur_cmd ^ 8'($urandom_range(1, 255)) : cur_cmd);
    add_byte(8'(len >> 8));
    add_byte(8'(len));
    n = chain ? 1 : (full ? 17 : $urandom_range(1, 17));
    if (n > len) n = len;
    remain = len - n;
    add_payload(n, fault == FLT_OVERRUN && remain == 0);
    send_packet(1'b1);
    seq = chain ? 1 : $urandom_range(0, 1);
    cut = $urandom_range(0, 2);
    while (remain > 0) begin
      if (!chain && $urandom_range(0, 5) == 0) begin
        add_byte(cur_ka);
        add_payload($urandom_range(0, 4), 1'b0);
        send_packet(1'b0);
      end
      if (cut == 0 && fault == FLT_PARTNER) begin
        add_byte(cur_err);
        add_payload($urandom_range(0, 3), 1'b0);
        send_packet(1'b0);
        break;
      end
      if (cut == 0 && fault == FLT_TRUNC) break;
      n = chain ? 1 : (full ? 19 : $urandom_range(1, 19));
      if (n > remain) n = remain;
      remain -= n;
      add_byte(8'((fault == FLT_SEQ && cut == 0) ? seq + 2 : seq));
      add_payload(n, fault == FLT_OVERRUN && remain == 0);
      send_packet(1'b1);
      seq++;
      cut--;
    end
    if ($urandom_range(0, 3) == 0) begin
      send_item(1'b0, 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int msg_no;
    int r;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    write_config(bufr_pkg::EXP_CMD_RST, bufr_pkg::KEEPALIVE_RST, bufr_pkg::ERROR_RST);

    // directed: restart, keep-alive, each error status, stray bytes
    send_item(1'b1, 8'hFF, 1'b1, 1'b1);
    send_item(1'b0, 8'h00, 1'b0, 1'b0);
    send_item(1'b0, bufr_pkg::EXP_CMD_RST, 1'b1, 1'b0);
    pkt_q = '{bufr_pkg::EXP_CMD_RST, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_packet(1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    pkt_q = '{bufr_pkg::KEEPALIVE_RST, 8'h01};
    send_packet(1'b0);
    pkt_q = '{bufr_pkg::EXP_CMD_RST, 8'h00, 8'h03, 8'hAA};
    send_packet(1'b0);
    pkt_q = '{8'h00, 8'h55, 8'h12};
    send_packet(1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    send_item(1'b0, bufr_pkg::ERROR_RST, 1'b1, 1'b1);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    send_item(1'b0, 8'h00, 1'b1, 1'b1);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    pkt_q = '{bufr_pkg::EXP_CMD_RST, 8'h00, 8'h01};
    send_packet(1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    pkt_q = '{bufr_pkg::EXP_CMD_RST, 8'h00, 8'h01, 8'h11, 8'h22};
    send_packet(1'b0);
    send_item(1'b1, 8'h00, 1'b0, 1'b0);
    pkt_q = '{bufr_pkg::EXP_CMD_RST, 8'h00, 8'h04, 8'h33};
    send_packet(1'b0);
    send_item(1'b0, 8'h05, 1'b1, 1'b0);
    wait_idle();

    msg_no = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (msg_no % 8 == 7) begin
        wait_idle();
        case ((msg_no / 8) % 5)
          0: write_config(8'd0, 8'd255, 8'd128);
          1: write_config(8'd255, 8'd0, 8'd253);
          2: write_config(8'd200, 8'd128, 8'd0);
          3: write_config(8'($urandom), 8'($urandom_range(128, 255)),
                          8'($urandom_range(128, 255)));
          default: write_config(bufr_pkg::EXP_CMD_RST, bufr_pkg::KEEPALIVE_RST,
                                bufr_pkg::ERROR_RST);
        endcase
      end
      quiet = ($urandom_range(0, 7) == 0);
      if (msg_no == 3) begin
        hold_requests++;
        quiet = 1'b1;
        send_message(120, 1'b1, 1'b0);
      end else if (msg_no == 5) begin
        send_message(140, 1'b0, 1'b1);
      end else begin
        r = $urandom_range(0, 29);
        if (r == 0) send_message(0, 1'b0, 1'b0);
        else if (r == 1) send_message($urandom_range(100, 300), 1'b1, 1'b0);
        else send_message($urandom_range(1, 40), r == 2, 1'b0);
      end
      msg_no++;
    end
    quiet = 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
